>>> hw/rtl/lpfs_pkg.sv
// Package: shared types, constants and the per-byte frame step of the frame stripper.
`timescale 1ns / 1ps
package lpfs_pkg;

	localparam int LPFS_HEADER_BYTES = 256;
	localparam int LPFS_PREFIX_BYTES = 4;
	localparam int LPFS_QDEPTH       = 4;

	localparam logic [16:0] TAG_INDEX  = 17'd16;
	localparam logic [16:0] FLAG_INDEX = 17'd17;
	localparam logic [7:0]  TAG_MARK   = 8'h1c;
	localparam logic [7:0]  FLAG_A     = 8'h80;
	localparam logic [7:0]  FLAG_B     = 8'h00;
	localparam logic [7:0]  FLAG_C     = 8'h40;
	localparam logic [7:0]  START_0    = 8'h01;
	localparam logic [7:0]  START_1    = 8'h00;
	localparam logic [7:0]  HDR_MIN    = 8'h01;

	typedef enum logic [1:0] {
		PH_DETECT = 2'd0,
		PH_SKIP   = 2'd1,
		PH_FRAME  = 2'd2
	} lpfs_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} lpfs_res_t;

	typedef struct packed {
		logic [1:0] n;
		lpfs_res_t  r0;
		lpfs_res_t  r1;
	} lpfs_out_t;

	typedef struct packed {
		logic [16:0] pos;
		logic [16:0] total;
		logic [7:0]  tag;
		logic [7:0]  held;
		logic        hvalid;
	} lpfs_frm_t;

	typedef struct packed {
		lpfs_frm_t st;
		lpfs_out_t o;
	} lpfs_step_t;

	function automatic lpfs_out_t lpfs_emit(input lpfs_out_t o, input logic [7:0] d,
		input logic l);
		lpfs_out_t r;
		r = o;
		if (o.n == 2'd0) begin
			r.r0 = '{data: d, last: l};
			r.n  = 2'd1;
		end else if (o.n == 2'd1) begin
			r.r1 = '{data: d, last: l};
			r.n  = 2'd2;
		end
		return r;
	endfunction

	function automatic lpfs_step_t lpfs_push(input lpfs_frm_t s, input logic [7:0] b,
		input lpfs_out_t o, input logic [16:0] prefix);
		lpfs_step_t r;
		logic       keep;
		logic       fin;
		r.st = s;
		r.o  = o;
		keep = 1'b1;
		if (s.pos == prefix - 17'd2) begin
			r.st.total = {9'd0, b};
		end else if (s.pos == prefix - 17'd1) begin
			r.st.total = {1'b0, s.total[7:0], b} + prefix;
		end
		if (s.pos == TAG_INDEX) begin
			r.st.tag = b;
			keep     = 1'b0;
		end else if (s.pos == FLAG_INDEX && s.tag == TAG_MARK
			&& (b inside {FLAG_A, FLAG_B, FLAG_C})) begin
			keep = 1'b0;
		end
		fin = (s.pos >= prefix - 17'd1) && (({1'b0, s.pos} + 18'd1) >= {1'b0, r.st.total});
		if (keep) begin
			if (s.hvalid) begin
				r.o = lpfs_emit(r.o, s.held, 1'b0);
			end
			if (fin) begin
				r.o         = lpfs_emit(r.o, b, 1'b1);
				r.st.hvalid = 1'b0;
			end else begin
				r.st.held   = b;
				r.st.hvalid = 1'b1;
			end
		end else if (fin && s.hvalid) begin
			r.o         = lpfs_emit(r.o, s.held, 1'b1);
			r.st.hvalid = 1'b0;
		end
		if (fin) begin
			r.st.pos   = '0;
			r.st.total = '0;
		end else begin
			r.st.pos = s.pos + 17'd1;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/length_prefixed_frame_stripper.sv
// A byte is registered, then decided and its results queued once the queue has room.
// One byte per cycle while there is room; results leave one per cycle from a four-entry queue.
// The queue admits a byte only when two result slots are free, as one byte may give two.
// Reset: arst_n clears phase, counters, frame state, held byte and queue at once; no clearing pass.
// Start bytes carry no reset and are always written before use.
`timescale 1ns / 1ps
module length_prefixed_frame_stripper #(
	parameter int HEADER_BYTES = lpfs_pkg::LPFS_HEADER_BYTES,
	parameter int PREFIX_BYTES = lpfs_pkg::LPFS_PREFIX_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_byte
);
	import lpfs_pkg::*;

	lpfs_out_t wr;
	logic      room;

	lpfs_core #(
		.HEADER_BYTES(HEADER_BYTES),
		.PREFIX_BYTES(PREFIX_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte (in_byte),
		.room    (room),
		.wr      (wr)
	);

	lpfs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.last_byte(last_byte)
	);

endmodule

>>> hw/rtl/lpfs_core.sv
// Core: input register, header detection and skip, per-frame byte filtering.
`timescale 1ns / 1ps
module lpfs_core #(
	parameter int HEADER_BYTES = lpfs_pkg::LPFS_HEADER_BYTES,
	parameter int PREFIX_BYTES = lpfs_pkg::LPFS_PREFIX_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                room,
	output lpfs_pkg::lpfs_out_t wr
);
	import lpfs_pkg::*;

	localparam logic [16:0] PREFIX = 17'(PREFIX_BYTES);
	localparam logic [8:0]  HDR_END = 9'(HEADER_BYTES);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	lpfs_phase_t phase_q, phase_d;
	logic [7:0]  hc_q, hc_d;
	logic [7:0]  start0_q, start1_q;
	lpfs_frm_t   frm_q;
	logic        hdr_match;
	logic        replay;
	logic        framing;
	lpfs_step_t  p1, p2, p3, res;

	assign advance   = valid_s1 && room;
	assign in_ready  = !valid_s1 || advance;
	assign hdr_match = (start0_q == START_0) && (start1_q == START_1) && (byte_s1 >= HDR_MIN);
	assign replay    = (phase_q == PH_DETECT) && (hc_q >= 8'd2) && !hdr_match;
	assign framing   = phase_q == PH_FRAME;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hc_d    = hc_q;
		case (phase_q)
			PH_DETECT: begin
				if (hc_q < 8'd2) begin
					hc_d = hc_q + 8'd1;
				end else if (hdr_match) begin
					hc_d    = 8'd3;
					phase_d = (HDR_END <= 9'd3) ? PH_FRAME : PH_SKIP;
				end else begin
					hc_d    = '0;
					phase_d = PH_FRAME;
				end
			end
			PH_SKIP: begin
				if ({1'b0, hc_q} + 9'd1 >= HDR_END) begin
					hc_d    = '0;
					phase_d = PH_FRAME;
				end else begin
					hc_d = hc_q + 8'd1;
				end
			end
			PH_FRAME: begin
				phase_d = PH_FRAME;
			end
			default: begin
				phase_d = PH_FRAME;
			end
		endcase
	end

	always_comb begin
		p1  = lpfs_push(frm_q, replay ? start0_q : byte_s1, '0, PREFIX);
		p2  = lpfs_push(p1.st, start1_q, p1.o, PREFIX);
		p3  = lpfs_push(p2.st, byte_s1, p2.o, PREFIX);
		res = replay ? p3 : p1;
		wr  = (advance && (replay || framing)) ? res.o : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DETECT;
			hc_q    <= '0;
			frm_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			if (replay || framing) begin
				frm_q <= res.st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && phase_q == PH_DETECT && hc_q < 8'd2) begin
			if (hc_q[0]) begin
				start1_q <= byte_s1;
			end else begin
				start0_q <= byte_s1;
			end
		end
	end

`ifndef SYNTHESIS
	a_detect_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DETECT |-> frm_q.pos == '0 && !frm_q.hvalid)
		else $error("frame state busy during header detection");
	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> {1'b0, hc_q} < HDR_END)
		else $error("header count past header end");
	a_push_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wr.n != 2'd0 |-> advance && (replay || framing))
		else $error("result pushed without a processed transaction");
`endif

endmodule

>>> hw/rtl/lpfs_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per transaction.
`timescale 1ns / 1ps
module lpfs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  lpfs_pkg::lpfs_out_t wr,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last_byte
);
	import lpfs_pkg::*;

	localparam int PW = $clog2(LPFS_QDEPTH);
	localparam int CW = $clog2(LPFS_QDEPTH + 1);

	lpfs_res_t     mem_q [LPFS_QDEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= CW'(LPFS_QDEPTH - 2);
	assign out_byte  = mem_q[head_q].data;
	assign last_byte = mem_q[head_q].last;

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) begin
			mem_q[tail_q] <= wr.r0;
		end
		if (wr.n == 2'd2) begin
			mem_q[tail_q + PW'(1)] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PW'(wr.n);
			head_q  <= head_q + PW'(pop);
			count_q <= count_q + CW'(wr.n) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.n != 2'd0 |-> room)
		else $error("push into a full result queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LPFS_QDEPTH))
		else $error("result queue count out of range");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(!arst_n) |-> count_q == $past(count_q) + CW'($past(wr.n)) - CW'($past(pop)))
		else $error("result queue count lost track");
`endif

endmodule
